/* src/cdtc_pkg.sv */
// Package: item types, register map, step and speed codes for the clamp drive controller.
`default_nettype none
package cdtc_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_CLAMPING_TORQUE  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_OPENING_DISTANCE = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_IN_POS_TOLERANCE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TEACH_TORQUE     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TORQUE_GAIN      = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SETTLE_TICKS     = 3'd5;

  localparam logic [16:0] CMP_STOP = 17'd64000;
  localparam logic [16:0] CMP_RUN  = 17'd72000;

  localparam logic DIR_IN  = 1'b0;
  localparam logic DIR_OUT = 1'b1;

  localparam logic [2:0] STEP_ENTER = 3'd0;
  localparam logic [2:0] STEP_READY = 3'd1;
  localparam logic [2:0] STEP_IN    = 3'd2;
  localparam logic [2:0] STEP_OUT   = 3'd3;
  localparam logic [2:0] STEP_END   = 3'd4;

  typedef struct packed {
    logic [15:0] clamping_torque;
    logic [31:0] opening_distance;
    logic [15:0] in_pos_tolerance;
    logic [14:0] teach_torque;
    logic [7:0]  torque_gain;
    logic [9:0]  settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic        enable;
    logic        stop_req;
    logic        teach_req;
    logic        close_req;
    logic        open_req;
    logic        end_switch;
    logic [31:0] position;
    logic [11:0] motor_current;
  } in_item_t;

  typedef struct packed {
    logic [16:0] speed_compare;
    logic        move_out;
    logic        encoder_reset;
    logic        in_position;
    logic        is_open;
    logic        is_closed;
    logic        clear_move_cmd;
    logic        clear_teach_cmd;
    logic        teach_active;
    logic [2:0]  teach_step;
  } out_item_t;

endpackage
`default_nettype wire

/* src/cdtc_chan_if.sv */
// Valid/ready channel interface carrying one item per handshake.
`default_nettype none
interface cdtc_chan_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/cdtc_cfg.sv */
// Configuration register file with write decode and reset values.
`default_nettype none
module cdtc_cfg
  import cdtc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                we_i,
  input  wire logic [CfgIdxW-1:0]  idx_i,
  input  wire logic [CfgDataW-1:0] wdata_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clamping_torque  <= 16'd1000;
      cfg_q.opening_distance <= 32'd0;
      cfg_q.in_pos_tolerance <= 16'd100;
      cfg_q.teach_torque     <= 15'd500;
      cfg_q.torque_gain      <= 8'd1;
      cfg_q.settle_ticks     <= 10'd50;
    end else if (we_i) begin
      case (idx_i)
        CFG_CLAMPING_TORQUE:  cfg_q.clamping_torque  <= wdata_i[15:0];
        CFG_OPENING_DISTANCE: cfg_q.opening_distance <= wdata_i;
        CFG_IN_POS_TOLERANCE: cfg_q.in_pos_tolerance <= wdata_i[15:0];
        CFG_TEACH_TORQUE:     cfg_q.teach_torque     <= wdata_i[14:0];
        CFG_TORQUE_GAIN:      cfg_q.torque_gain      <= wdata_i[7:0];
        CFG_SETTLE_TICKS:     cfg_q.settle_ticks     <= wdata_i[9:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

/* src/cdtc_core.sv */
// Control tick logic: operating and teach state, drive decisions and result item.
`default_nettype none
module cdtc_core
  import cdtc_pkg::*;
#(
  parameter int POSITION_WIDTH = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire cfg_t     cfg_i,
  input  wire in_item_t item_i,
  output out_item_t     res_o
);

  localparam int PosW = POSITION_WIDTH;
  localparam int WinW = 34;

  logic                   mode_q, mode_d;
  logic [2:0]             sn_q, sn_d;
  logic [2:0]             snx_q, snx_d;
  logic signed [PosW-1:0] home_q, home_d;
  logic signed [PosW-1:0] prev_q, prev_d;
  logic [9:0]             cnt_q, cnt_d;
  logic                   armed_q, armed_d;
  logic [16:0]            cmp_q, cmp_d;
  logic                   dir_q, dir_d;
  logic                   ip_q, ip_d;
  logic                   op_q, op_d;
  logic                   cl_q, cl_d;

  logic signed [PosW-1:0] pos_in;
  logic [19:0]            torque;
  logic                   over_clamp, over_teach, over_teach2;
  logic signed [WinW-1:0] pos_w, win_hi, win_lo;

  assign pos_in      = $signed(item_i.position[PosW-1:0]);
  assign torque      = {8'd0, item_i.motor_current} * {12'd0, cfg_i.torque_gain};
  assign over_clamp  = torque > {4'd0, cfg_i.clamping_torque};
  assign over_teach  = torque > {5'd0, cfg_i.teach_torque};
  assign over_teach2 = torque > {4'd0, cfg_i.teach_torque, 1'b0};
  assign pos_w       = WinW'(pos_in);
  assign win_hi      = WinW'($signed(cfg_i.opening_distance)) + $signed({18'd0, cfg_i.in_pos_tolerance});
  assign win_lo      = WinW'($signed(cfg_i.opening_distance)) - $signed({18'd0, cfg_i.in_pos_tolerance});

  always_comb begin
    logic signed [PosW-1:0] pos_v;
    logic [9:0]             s_cnt;
    logic                   s_done;
    logic [9:0]             s_next;
    logic                   do_home;
    logic                   home_done;
    logic                   enc, mv, tc;

    mode_d    = mode_q;
    sn_d      = sn_q;
    snx_d     = snx_q;
    home_d    = home_q;
    prev_d    = prev_q;
    cnt_d     = cnt_q;
    armed_d   = armed_q;
    cmp_d     = cmp_q;
    dir_d     = dir_q;
    ip_d      = ip_q;
    op_d      = op_q;
    cl_d      = cl_q;
    pos_v     = pos_in;
    enc       = 1'b0;
    mv        = 1'b0;
    tc        = 1'b0;
    do_home   = 1'b0;
    home_done = 1'b0;
    s_cnt     = '0;
    s_done    = 1'b0;
    s_next    = '0;

    if (!item_i.enable || item_i.stop_req) begin
      cmp_d = CMP_STOP;
    end else begin
      if (item_i.teach_req) begin
        tc      = 1'b1;
        home_d  = '0;
        prev_d  = '0;
        sn_d    = STEP_ENTER;
        snx_d   = STEP_ENTER;
        armed_d = 1'b0;
        mode_d  = 1'b1;
      end
      // settle delay as it would advance if used this tick
      s_cnt  = armed_d ? cnt_q : cfg_i.settle_ticks;
      s_done = (s_cnt == 10'd0);
      s_next = s_done ? 10'd0 : s_cnt - 10'd1;

      if (mode_d) begin
        sn_d = snx_d;
        case (sn_d)
          STEP_ENTER: begin
            if (!item_i.end_switch) snx_d = STEP_READY;
          end
          STEP_READY: begin
            if (item_i.end_switch) begin
              enc    = 1'b1;
              home_d = '0;
              pos_v  = '0;
              prev_d = '0;
              snx_d  = STEP_OUT;
            end
          end
          STEP_IN: begin
            if (item_i.end_switch) begin
              cnt_d   = s_next;
              armed_d = 1'b1;
              if (s_done && over_teach) begin
                cmp_d   = CMP_STOP;
                home_d  = -pos_v;
                armed_d = 1'b0;
                enc     = 1'b1;
                tc      = 1'b1;
                snx_d   = STEP_END;
              end else begin
                dir_d = DIR_IN;
                cmp_d = CMP_RUN;
              end
            end else begin
              cmp_d = CMP_STOP;
              if (pos_v == prev_d) begin
                cnt_d   = s_next;
                armed_d = 1'b1;
                if (s_done) begin
                  armed_d = 1'b0;
                  snx_d   = STEP_OUT;
                end
              end
            end
          end
          STEP_OUT: begin
            if (item_i.end_switch) begin
              cmp_d = CMP_STOP;
              if (pos_v == prev_d) begin
                cnt_d   = s_next;
                armed_d = 1'b1;
                if (s_done) begin
                  armed_d = 1'b0;
                  snx_d   = STEP_IN;
                end
              end
            end else begin
              do_home = 1'b1;
            end
          end
          STEP_END: begin
            do_home = 1'b1;
          end
          default: ;
        endcase

        // drive back toward home position
        if (do_home) begin
          if (pos_v <= home_d) begin
            cmp_d     = CMP_STOP;
            armed_d   = 1'b0;
            home_done = 1'b1;
          end else begin
            cnt_d   = s_next;
            armed_d = 1'b1;
            if (s_done && over_teach2) begin
              cmp_d     = CMP_STOP;
              armed_d   = 1'b0;
              home_done = 1'b1;
            end else begin
              dir_d = DIR_OUT;
              cmp_d = CMP_RUN;
            end
          end
        end
        if (home_done && (sn_d == STEP_END)) mode_d = 1'b0;
        prev_d = pos_v;
      end else begin
        if (item_i.close_req) begin
          if (over_clamp) begin
            ip_d  = 1'b1;
            cl_d  = 1'b1;
            op_d  = 1'b0;
            mv    = 1'b1;
            cmp_d = CMP_STOP;
          end else begin
            dir_d = DIR_IN;
            cmp_d = CMP_RUN;
          end
        end else if (item_i.open_req) begin
          if (pos_w > win_lo) begin
            if (over_clamp) begin
              cmp_d = CMP_STOP;
            end else begin
              dir_d = DIR_OUT;
              cmp_d = CMP_RUN;
            end
          end
          if (pos_w > win_hi) begin
            if (over_clamp) begin
              cmp_d = CMP_STOP;
            end else begin
              dir_d = DIR_IN;
              cmp_d = CMP_RUN;
            end
          end
          if ((pos_w < win_hi) && (pos_w > win_lo)) begin
            ip_d  = 1'b1;
            op_d  = 1'b1;
            cl_d  = 1'b0;
            mv    = 1'b1;
            cmp_d = CMP_STOP;
          end
        end else begin
          cmp_d = CMP_STOP;
        end
      end
    end

    res_o.speed_compare   = cmp_d;
    res_o.move_out        = dir_d;
    res_o.encoder_reset   = enc;
    res_o.in_position     = ip_d;
    res_o.is_open         = op_d;
    res_o.is_closed       = cl_d;
    res_o.clear_move_cmd  = mv;
    res_o.clear_teach_cmd = tc;
    res_o.teach_active    = mode_d;
    res_o.teach_step      = sn_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      sn_q    <= STEP_ENTER;
      snx_q   <= STEP_ENTER;
      home_q  <= '0;
      prev_q  <= '0;
      cnt_q   <= '0;
      armed_q <= 1'b0;
      cmp_q   <= CMP_STOP;
      dir_q   <= DIR_IN;
      ip_q    <= 1'b0;
      op_q    <= 1'b0;
      cl_q    <= 1'b0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      sn_q    <= sn_d;
      snx_q   <= snx_d;
      home_q  <= home_d;
      prev_q  <= prev_d;
      cnt_q   <= cnt_d;
      armed_q <= armed_d;
      cmp_q   <= cmp_d;
      dir_q   <= dir_d;
      ip_q    <= ip_d;
      op_q    <= op_d;
      cl_q    <= cl_d;
    end
  end

endmodule
`default_nettype wire

/* src/clamp_drive_teach_controller_unit.sv */
// Top level: input register, control tick core, result register and config port.
//
//  channel   dir  payload     handshake
//  in_i      in   in_item_t   valid/ready
//  out_o     out  out_item_t  valid/ready
//  cfg       in   idx, data   cfg_we_i, no wait
//
// Each item passes the input register, then the combinational tick logic into the
// result register; one item per cycle sustained while the output is not stalled.
// The input register takes a new item while the result register drains.
// A stalled output holds the result and blocks the input stage only when full.
// Reset clears handshake state, drive state and config to their reset values.
`default_nettype none
module clamp_drive_teach_controller_unit
  import cdtc_pkg::*;
#(
  parameter int POSITION_WIDTH = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  cdtc_chan_if.sink                in_i,
  cdtc_chan_if.source              out_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t      cfg;
  logic      in_vq;
  in_item_t  in_dq;
  logic      out_vq;
  out_item_t out_dq;
  out_item_t res;
  logic      adv;

  assign adv         = in_vq && (!out_vq || out_o.ready);
  assign in_i.ready  = !in_vq || adv;
  assign out_o.valid = out_vq;
  assign out_o.data  = out_dq;

  cdtc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  cdtc_core #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .cfg_i  (cfg),
    .item_i (in_dq),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq  <= 1'b0;
      out_vq <= 1'b0;
    end else begin
      if (in_i.ready) in_vq <= in_i.valid;
      if (adv) begin
        out_vq <= 1'b1;
      end else if (out_o.ready) begin
        out_vq <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) in_dq <= in_i.data;
    if (adv) out_dq <= res;
  end

  a_adv_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vq)
    else $error("tick result not registered");

  a_speed_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vq |-> (out_dq.speed_compare == CMP_STOP || out_dq.speed_compare == CMP_RUN))
    else $error("speed compare not a valid code");

  a_status_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vq |-> !(out_dq.is_open && out_dq.is_closed))
    else $error("open and closed both set");

  a_enc_teach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vq && out_dq.encoder_reset) |-> out_dq.teach_active)
    else $error("encoder reset outside teach");

  a_move_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vq && out_dq.clear_move_cmd) |-> !out_dq.teach_active)
    else $error("move clear during teach");

endmodule
`default_nettype wire

/* dv/tb.sv */
// Testbench: control ticks into the clamp drive controller, each result checked against a tick model.
`timescale 1ns / 1ps
module tb;
  import cdtc_pkg::*;

  localparam int CycleLimit = 400000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  cdtc_chan_if #(.item_t(in_item_t)) in_ch ();
  cdtc_chan_if #(.item_t(out_item_t)) out_ch ();

  clamp_drive_teach_controller_unit #(.POSITION_WIDTH(32)) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // model configuration
  logic [15:0] m_clamp;
  logic signed [31:0] m_od;
  logic [15:0] m_tol;
  logic [14:0] m_teach_tq;
  logic [7:0] m_gain;
  logic [9:0] m_settle;

  // model state
  logic m_teach;
  logic [2:0] m_step, m_step_nxt;
  logic signed [31:0] m_home, m_prev;
  logic [15:0] m_dly;
  logic m_armed;
  logic [16:0] m_cmp;
  logic m_dir;
  logic m_in_pos, m_open, m_closed;

  // per-tick values
  logic [11:0] t_cur;
  logic signed [31:0] t_pos;
  logic t_enc, t_move, t_teachp;

  out_item_t pending_results[$];
  out_item_t want;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int settings_used = 0;
  int teach_done_count = 0;
  int clamp_count = 0;
  int open_count = 0;
  int cycles = 0;
  int src_idle_pct = 7;
  int sink_idle_pct = 54;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit torque_over(int unsigned limit);
    int unsigned torque;
    torque = int'(t_cur) * int'(m_gain);
    return torque > limit;
  endfunction

  function automatic bit run_motor(logic dir, int unsigned limit, bit no_check);
    if (!no_check && torque_over(limit)) begin
      m_cmp = CMP_STOP;
      return 1'b1;
    end
    m_dir = dir;
    m_cmp = CMP_RUN;
    return 1'b0;
  endfunction

  function automatic bit settle_done();
    if (!m_armed) begin
      m_dly = 16'(m_settle);
      m_armed = 1'b1;
    end
    if (m_dly == 16'd0) return 1'b1;
    m_dly = m_dly - 16'd1;
    return 1'b0;
  endfunction

  function automatic bit return_home();
    bit no_check;
    if (t_pos <= m_home) begin
      m_cmp = CMP_STOP;
      m_armed = 1'b0;
      return 1'b1;
    end
    no_check = !settle_done();
    if (run_motor(DIR_OUT, int'(m_teach_tq) * 2, no_check)) begin
      m_cmp = CMP_STOP;
      m_armed = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void teach_tick(logic sw);
    bit no_check;
    m_step = m_step_nxt;
    case (m_step)
      STEP_ENTER: if (!sw) m_step_nxt = STEP_READY;
      STEP_READY: begin
        if (sw) begin
          t_enc = 1'b1;
          m_home = '0;
          t_pos = '0;
          m_prev = '0;
          m_step_nxt = STEP_OUT;
        end
      end
      STEP_IN: begin
        if (sw) begin
          no_check = !settle_done();
          if (run_motor(DIR_IN, int'(m_teach_tq), no_check)) begin
            m_cmp = CMP_STOP;
            m_home = -t_pos;
            m_armed = 1'b0;
            t_enc = 1'b1;
            t_teachp = 1'b1;
            m_step_nxt = STEP_END;
          end
        end else begin
          m_cmp = CMP_STOP;
          if (t_pos == m_prev) begin
            if (settle_done()) begin
              m_armed = 1'b0;
              m_step_nxt = STEP_OUT;
            end
          end
        end
      end
      STEP_OUT: begin
        if (sw) begin
          m_cmp = CMP_STOP;
          if (t_pos == m_prev) begin
            if (settle_done()) begin
              m_armed = 1'b0;
              m_step_nxt = STEP_IN;
            end
          end
        end else begin
          if (return_home()) m_cmp = CMP_STOP;
        end
      end
      STEP_END: begin
        if (return_home()) begin
          m_teach = 1'b0;
          teach_done_count++;
        end
      end
      default: ;
    endcase
    m_prev = t_pos;
  endfunction

  function automatic void operate_tick(logic cls, logic opn);
    longint hi, lo, p;
    if (cls) begin
      if (run_motor(DIR_IN, int'(m_clamp), 1'b0)) begin
        m_in_pos = 1'b1;
        m_closed = 1'b1;
        m_open = 1'b0;
        t_move = 1'b1;
        m_cmp = CMP_STOP;
        clamp_count++;
      end
    end else if (opn) begin
      hi = longint'(m_od) + longint'(m_tol);
      lo = longint'(m_od) - longint'(m_tol);
      p = longint'(t_pos);
      if (p > lo) void'(run_motor(DIR_OUT, int'(m_clamp), 1'b0));
      if (p > hi) void'(run_motor(DIR_IN, int'(m_clamp), 1'b0));
      if (p < hi && p > lo) begin
        m_in_pos = 1'b1;
        m_open = 1'b1;
        m_closed = 1'b0;
        t_move = 1'b1;
        m_cmp = CMP_STOP;
        open_count++;
      end
    end else begin
      m_cmp = CMP_STOP;
    end
  endfunction

  function automatic out_item_t predict_tick(in_item_t it);
    out_item_t r;
    t_pos = it.position;
    t_cur = it.motor_current;
    t_enc = 1'b0;
    t_move = 1'b0;
    t_teachp = 1'b0;
    if (!it.enable || it.stop_req) begin
      m_cmp = CMP_STOP;
    end else begin
      if (it.teach_req) begin
        t_teachp = 1'b1;
        m_home = '0;
        m_prev = '0;
        m_step = STEP_ENTER;
        m_step_nxt = STEP_ENTER;
        m_armed = 1'b0;
        m_teach = 1'b1;
      end
      if (m_teach) teach_tick(it.end_switch);
      else operate_tick(it.close_req, it.open_req);
    end
    r.speed_compare = m_cmp;
    r.move_out = m_dir;
    r.encoder_reset = t_enc;
    r.in_position = m_in_pos;
    r.is_open = m_open;
    r.is_closed = m_closed;
    r.clear_move_cmd = t_move;
    r.clear_teach_cmd = t_teachp;
    r.teach_active = m_teach;
    r.teach_step = m_step;
    return r;
  endfunction

  task automatic model_reset();
    m_clamp = 16'd1000;
    m_od = '0;
    m_tol = 16'd100;
    m_teach_tq = 15'd500;
    m_gain = 8'd1;
    m_settle = 10'd50;
    m_teach = 1'b0;
    m_step = STEP_ENTER;
    m_step_nxt = STEP_ENTER;
    m_home = '0;
    m_prev = '0;
    m_dly = '0;
    m_armed = 1'b0;
    m_cmp = CMP_STOP;
    m_dir = DIR_IN;
    m_in_pos = 1'b0;
    m_open = 1'b0;
    m_closed = 1'b0;
  endtask

  function automatic in_item_t make_item(bit en, bit stp, bit tch, bit cls, bit opn, bit sw,
                                         logic [31:0] pos, logic [11:0] cur);
    in_item_t it;
    it.enable = en;
    it.stop_req = stp;
    it.teach_req = tch;
    it.close_req = cls;
    it.open_req = opn;
    it.end_switch = sw;
    it.position = pos;
    it.motor_current = cur;
    return it;
  endfunction

  task automatic send_tick(in_item_t it);
    @(negedge clk);
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_ch.valid = 1'b1;
    in_ch.data = it;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_tick(it));
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = val;
    case (idx)
      CFG_CLAMPING_TORQUE:  m_clamp = val[15:0];
      CFG_OPENING_DISTANCE: m_od = val;
      CFG_IN_POS_TOLERANCE: m_tol = val[15:0];
      CFG_TEACH_TORQUE:     m_teach_tq = val[14:0];
      CFG_TORQUE_GAIN:      m_gain = val[7:0];
      CFG_SETTLE_TICKS:     m_settle = val[9:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic apply_setting(int unsigned clamp, logic [31:0] od, int unsigned tol,
                               int unsigned tq, int unsigned gain, int unsigned settle);
    wait_drained();
    write_reg(CFG_CLAMPING_TORQUE, clamp);
    write_reg(CFG_OPENING_DISTANCE, od);
    write_reg(CFG_IN_POS_TOLERANCE, tol);
    write_reg(CFG_TEACH_TORQUE, tq);
    write_reg(CFG_TORQUE_GAIN, gain);
    write_reg(CFG_SETTLE_TICKS, settle);
    settings_used++;
  endtask

  // Steers the item by the model's mode and step so teach runs get deep.
  function automatic in_item_t next_random_tick();
    in_item_t it;
    int tol, offs, thr;
    it.enable = ($urandom_range(99) < 96);
    it.stop_req = ($urandom_range(99) < 3);
    it.teach_req = ($urandom_range(99) < 2);
    it.close_req = $urandom_range(1);
    it.open_req = $urandom_range(1);
    it.end_switch = $urandom_range(1);
    it.position = $urandom;
    it.motor_current = $urandom_range(4095);
    if ($urandom_range(99) < 8) begin
      it.enable = $urandom_range(1);
      it.stop_req = $urandom_range(1);
      return it;
    end
    if (m_teach) begin
      if ($urandom_range(99) < 75) it.motor_current = $urandom_range(8);
      case (m_step_nxt)
        STEP_ENTER: it.end_switch = ($urandom_range(99) < 20);
        STEP_READY: it.end_switch = ($urandom_range(99) < 85);
        STEP_IN, STEP_OUT: begin
          it.end_switch = ($urandom_range(99) < 80);
          it.position = ($urandom_range(99) < 80) ? m_prev : m_prev - $urandom_range(40);
        end
        default: begin
          it.position = ($urandom_range(99) < 30) ? m_home - $urandom_range(3)
                                                   : m_home + $urandom_range(200, 1);
        end
      endcase
    end else begin
      it.teach_req = ($urandom_range(99) < 5);
      tol = int'(m_tol);
      offs = $urandom_range(2 * tol + 4) - tol - 2;
      if ($urandom_range(99) < 25) offs = $urandom_range(1) ? tol : -tol;
      if ($urandom_range(99) < 90) it.position = m_od + offs;
      if ($urandom_range(99) < 50 && m_gain != 8'd0) begin
        thr = int'(m_clamp) / int'(m_gain) + int'($urandom_range(2)) - 1;
        if (thr < 0) thr = 0;
        if (thr > 4095) thr = 4095;
        it.motor_current = thr[11:0];
      end
    end
    return it;
  endfunction

  task automatic test_operating_directed();
    send_tick(make_item(0, 1, 1, 1, 1, 1, 32'h7FFF_FFFF, 12'hFFF));
    send_tick(make_item(1, 1, 1, 1, 1, 1, 32'h8000_0000, 12'h000));
    send_tick(make_item(1, 0, 0, 1, 0, 0, 32'd0, 12'd1000));
    send_tick(make_item(1, 0, 0, 1, 0, 0, 32'd0, 12'd1001));
    send_tick(make_item(1, 0, 0, 1, 1, 0, 32'h8000_0000, 12'd0));
    send_tick(make_item(1, 0, 0, 0, 1, 0, 32'h8000_0000, 12'd0));
    send_tick(make_item(1, 0, 0, 0, 1, 0, -32'sd100, 12'd0));
    send_tick(make_item(1, 0, 0, 0, 1, 0, 32'd100, 12'd0));
    send_tick(make_item(1, 0, 0, 0, 1, 0, 32'd101, 12'd0));
    send_tick(make_item(1, 0, 0, 0, 1, 1, 32'h7FFF_FFFF, 12'hFFF));
    send_tick(make_item(1, 0, 0, 0, 1, 0, 32'd50, 12'd0));
    send_tick(make_item(1, 0, 0, 0, 0, 0, 32'd50, 12'd0));
  endtask

  task automatic test_teach_directed();
    apply_setting(1000, 32'd0, 100, 10, 1, 0);
    send_tick(make_item(1, 0, 1, 0, 0, 1, 32'd0, 12'd0));
    send_tick(make_item(1, 0, 0, 0, 0, 0, 32'd0, 12'd0));
    send_tick(make_item(1, 0, 0, 0, 0, 1, 32'd12345, 12'd0));
    send_tick(make_item(1, 0, 0, 0, 0, 1, 32'd0, 12'd0));
    // most negative position negates to itself
    send_tick(make_item(1, 0, 0, 0, 0, 1, 32'h8000_0000, 12'hFFF));
    send_tick(make_item(1, 0, 0, 0, 0, 0, 32'd5, 12'd0));
    send_tick(make_item(0, 0, 0, 0, 0, 0, 32'd5, 12'd0));
    send_tick(make_item(1, 0, 0, 0, 0, 0, 32'h8000_0000, 12'd0));
    send_tick(make_item(1, 0, 1, 0, 0, 0, 32'd0, 12'd0));
    send_tick(make_item(1, 0, 0, 0, 0, 1, 32'd7, 12'd0));
    send_tick(make_item(1, 0, 0, 0, 0, 1, 32'd0, 12'd0));
    send_tick(make_item(1, 0, 0, 0, 0, 0, 32'd0, 12'd0));
    send_tick(make_item(1, 0, 0, 0, 0, 0, 32'd0, 12'd0));
    send_tick(make_item(1, 0, 1, 0, 0, 1, 32'd9, 12'd0));
  endtask

  task automatic test_random_ticks(int n_items);
    int per_phase;
    per_phase = n_items / 9;
    for (int ph = 0; ph < 9; ph++) begin
      src_idle_pct = (ph < 3) ? 7 : (ph < 6) ? 54 : 0;
      sink_idle_pct = (ph < 3) ? 54 : (ph < 6) ? 7 : 0;
      case (ph)
        1: apply_setting(0, 32'h8000_0000, 0, 0, 0, 0);
        3: apply_setting(16'hFFFF, 32'h7FFF_FFFF, 16'hFFFF, 15'h7FFF, 8'hFF, 10'd1023);
        7: apply_setting(1000, 32'd0, 100, 500, 1, 50);
        default: apply_setting($urandom_range(6000, 200), $urandom, $urandom_range(300),
                               $urandom_range(3000, 50), $urandom_range(6, 1),
                               $urandom_range(6));
      endcase
      for (int k = 0; k < per_phase; k++) begin
        if (k == per_phase / 2) wait_drained();
        send_tick(next_random_tick());
      end
    end
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(negedge clk) out_ch.ready = ($urandom_range(99) >= sink_idle_pct);

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result with no item pending", $time);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("speed_compare", want.speed_compare, out_ch.data.speed_compare);
        check_field("move_out", want.move_out, out_ch.data.move_out);
        check_field("encoder_reset", want.encoder_reset, out_ch.data.encoder_reset);
        check_field("in_position", want.in_position, out_ch.data.in_position);
        check_field("is_open", want.is_open, out_ch.data.is_open);
        check_field("is_closed", want.is_closed, out_ch.data.is_closed);
        check_field("clear_move_cmd", want.clear_move_cmd, out_ch.data.clear_move_cmd);
        check_field("clear_teach_cmd", want.clear_teach_cmd, out_ch.data.clear_teach_cmd);
        check_field("teach_active", want.teach_active, out_ch.data.teach_active);
        check_field("teach_step", want.teach_step, out_ch.data.teach_step);
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               pending_results.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    model_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_operating_directed();
    test_teach_directed();
    test_random_ticks(1000);
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Covered %0d items under %0d register settings, %0d results compared.",
             items_sent, settings_used, results_seen);
    $display("Teach runs finished: %0d, clamp events: %0d, open events: %0d.",
             teach_done_count, clamp_count, open_count);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
src/cdtc_pkg.sv
src/cdtc_chan_if.sv
src/cdtc_cfg.sv
src/cdtc_core.sv
src/clamp_drive_teach_controller_unit.sv
dv/tb.sv
